### rtl/d2p_pkg.sv
package d2p_pkg;

    // register indexes of the configuration port
    typedef enum logic [2:0] {
        CFG_BASELINE = 3'd0,
        CFG_FOCAL    = 3'd1,
        CFG_CENTER_X = 3'd2,
        CFG_CENTER_Y = 3'd3,
        CFG_SCALE    = 3'd4,
        CFG_LIMIT    = 3'd5
    } t_cfg_idx;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // divider cell widths and cell counts
    localparam int NUM_W   = 48;
    localparam int DEN_W   = 16;
    localparam int DEPTH_N = 32;   // cells for the depth quotient
    localparam int ZQ_N    = 32;   // cells for the z quotient
    localparam int LAT_N   = 48;   // cells for the lateral quotients

    typedef struct packed {
        logic [11:0]        column;
        logic [11:0]        row;
        logic signed [15:0] disparity;
        logic [7:0]         blue_in;
        logic [7:0]         green_in;
        logic [7:0]         red_in;
    } t_pixel;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic [30:0]        point_z;
        logic [7:0]         blue_out;
        logic [7:0]         green_out;
        logic [7:0]         red_out;
    } t_point;

    // data that rides along with an item through the divider cells
    typedef struct packed {
        logic [11:0] column;
        logic [11:0] row;
        logic [7:0]  blue;
        logic [7:0]  green;
        logic [7:0]  red;
        logic [31:0] aux;
        logic        neg_x;
        logic        neg_y;
    } t_side;

    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] rem;
        logic [NUM_W-1:0] quo;
        logic [DEN_W-1:0] den;
        t_side            side;
    } t_div;

endpackage

### rtl/d2p_div_cell.sv
module d2p_div_cell
    import d2p_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_v,
    input  t_div i_d,
    output logic o_v,
    output t_div o_d
);

    logic [DEN_W:0] trial;
    logic [DEN_W:0] diff;
    logic           take;
    t_div           n_d;
    logic           r_v;
    t_div           r_d;

    // one restoring step: bring down the next numerator bit
    always_comb begin
        trial = {i_d.rem, i_d.num[NUM_W-1]};
        diff  = trial - {1'b0, i_d.den};
        take  = (trial >= {1'b0, i_d.den});
        n_d      = i_d;
        n_d.num  = {i_d.num[NUM_W-2:0], 1'b0};
        n_d.rem  = take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        n_d.quo  = {i_d.quo[NUM_W-2:0], take};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else begin
            r_v <= i_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d <= n_d;
    end

    assign o_v = r_v;
    assign o_d = r_d;

`ifndef SYNTHESIS
    // the partial remainder stays below the divisor
    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v |-> ({1'b0, r_d.rem} < {1'b0, r_d.den}))
        else $error("remainder not below divisor");
    // a live item never carries a zero divisor
    a_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v |-> (r_d.den != '0))
        else $error("zero divisor in live item");
    // quotient bit is set whenever the trial covered the divisor
    a_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_v && ({i_d.rem, i_d.num[NUM_W-1]} >= {1'b0, i_d.den}) |=> r_d.quo[0])
        else $error("quotient bit lost");
`endif

endmodule

### rtl/disparity_to_point_reproject.sv
// channel  | dir | handshake                | payload
// pixel    | in  | i_start high, o_busy low | i_pixel (t_pixel)
// point    | out | o_valid strobe, 1 cycle  | o_point (t_point)
// config   | in  | i_cfg_we                 | i_cfg_idx, i_cfg_data
//
// one pixel per cycle; o_busy stays low, the pipeline always moves
// stages in order: input stage, 32 depth divider cells, a check stage,
// 32 z divider cells, offset and multiply stages, 48 lateral cells, output stage
// pixels without a point leave a bubble and no strobe
// synchronous active-low reset clears valid flags and loads register defaults
module disparity_to_point_reproject
    import d2p_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    output logic                  o_busy,
    input  t_pixel                i_pixel,
    output logic                  o_valid,
    output t_point                o_point,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [15:0] r_baseline, r_focal, r_cx, r_cy, r_scale, r_limit;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_baseline <= 16'd0;
            r_focal    <= 16'd16;
            r_cx       <= 16'd0;
            r_cy       <= 16'd0;
            r_scale    <= 16'd1000;
            r_limit    <= 16'd20000;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_BASELINE: r_baseline <= i_cfg_data;
                CFG_FOCAL:    r_focal    <= i_cfg_data;
                CFG_CENTER_X: r_cx       <= i_cfg_data;
                CFG_CENTER_Y: r_cy       <= i_cfg_data;
                CFG_SCALE:    r_scale    <= i_cfg_data;
                CFG_LIMIT:    r_limit    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_busy = 1'b0;

    // input stage: keep pixels with positive disparity
    logic               r_a_v;
    logic signed [15:0] r_a_disp;
    logic [31:0]        r_a_bf;
    t_side              r_a_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else begin
            r_a_v <= i_start && !o_busy && !i_pixel.disparity[15]
                     && (i_pixel.disparity != 16'sd0);
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_disp        <= i_pixel.disparity;
        r_a_bf          <= {16'd0, r_baseline} * {16'd0, r_focal};
        r_a_side.column <= i_pixel.column;
        r_a_side.row    <= i_pixel.row;
        r_a_side.blue   <= i_pixel.blue_in;
        r_a_side.green  <= i_pixel.green_in;
        r_a_side.red    <= i_pixel.red_in;
        r_a_side.aux    <= 32'd0;
        r_a_side.neg_x  <= 1'b0;
        r_a_side.neg_y  <= 1'b0;
    end

    // depth divider chain
    logic [DEPTH_N:0] dv;
    t_div             dd [DEPTH_N+1];

    assign dv[0]       = r_a_v;
    assign dd[0].num   = {r_a_bf, 16'd0};
    assign dd[0].rem   = '0;
    assign dd[0].quo   = '0;
    assign dd[0].den   = {1'b0, r_a_disp[14:0]};
    assign dd[0].side  = r_a_side;

    for (genvar g = 0; g < DEPTH_N; g++) begin : g_depth
        d2p_div_cell u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n),
            .i_v(dv[g]), .i_d(dd[g]), .o_v(dv[g+1]), .o_d(dd[g+1])
        );
    end

    // depth range check
    logic        r_b_v;
    logic [15:0] r_b_depth;
    t_side       r_b_side;
    logic [31:0] depth_q;

    assign depth_q = dd[DEPTH_N].quo[31:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
        end else begin
            r_b_v <= dv[DEPTH_N] && (depth_q != 32'd0)
                     && (depth_q <= {16'd0, r_limit});
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_depth <= depth_q[15:0];
        r_b_side  <= dd[DEPTH_N].side;
    end

    // z divider chain
    logic [ZQ_N:0] zv;
    t_div          zd [ZQ_N+1];

    assign zv[0]      = r_b_v;
    assign zd[0].num  = {r_b_depth, 32'd0};
    assign zd[0].rem  = '0;
    assign zd[0].quo  = '0;
    assign zd[0].den  = (r_scale == 16'd0) ? 16'd1 : r_scale;
    assign zd[0].side = r_b_side;

    for (genvar g = 0; g < ZQ_N; g++) begin : g_zq
        d2p_div_cell u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n),
            .i_v(zv[g]), .i_d(zd[g]), .o_v(zv[g+1]), .o_d(zd[g+1])
        );
    end

    // offsets from the principal point, split into sign and magnitude
    logic signed [17:0] off_x, off_y, neg_off_x, neg_off_y;
    t_side              c_side;
    logic               r_c_v;
    logic [15:0]        r_c_mx, r_c_my;
    t_side              r_c_side;

    always_comb begin
        off_x = $signed({2'b00, zd[ZQ_N].side.column, 4'd0}) - $signed({2'b00, r_cx});
        off_y = $signed({2'b00, zd[ZQ_N].side.row, 4'd0}) - $signed({2'b00, r_cy});
        neg_off_x = -off_x;
        neg_off_y = -off_y;
        c_side       = zd[ZQ_N].side;
        c_side.aux   = zd[ZQ_N].quo[31:0];
        c_side.neg_x = off_x[17];
        c_side.neg_y = off_y[17];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_v <= 1'b0;
        end else begin
            r_c_v <= zv[ZQ_N];
        end
    end

    always_ff @(posedge i_clk) begin
        r_c_mx   <= off_x[17] ? neg_off_x[15:0] : off_x[15:0];
        r_c_my   <= off_y[17] ? neg_off_y[15:0] : off_y[15:0];
        r_c_side <= c_side;
    end

    // products of offset magnitude and z
    logic        r_d_v;
    logic [47:0] r_d_px, r_d_py;
    t_side       r_d_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_v <= 1'b0;
        end else begin
            r_d_v <= r_c_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d_px   <= {32'd0, r_c_mx} * {16'd0, r_c_side.aux};
        r_d_py   <= {32'd0, r_c_my} * {16'd0, r_c_side.aux};
        r_d_side <= r_c_side;
    end

    // lateral divider chains, x and y side by side
    logic [LAT_N:0] xv, yv;
    t_div           xd [LAT_N+1];
    t_div           yd [LAT_N+1];

    assign xv[0]      = r_d_v;
    assign xd[0].num  = r_d_px;
    assign xd[0].rem  = '0;
    assign xd[0].quo  = '0;
    assign xd[0].den  = r_focal;
    assign xd[0].side = r_d_side;

    assign yv[0]      = r_d_v;
    assign yd[0].num  = r_d_py;
    assign yd[0].rem  = '0;
    assign yd[0].quo  = '0;
    assign yd[0].den  = r_focal;
    assign yd[0].side = r_d_side;

    for (genvar g = 0; g < LAT_N; g++) begin : g_lat
        d2p_div_cell u_xcell (
            .i_clk(i_clk), .i_rst_n(i_rst_n),
            .i_v(xv[g]), .i_d(xd[g]), .o_v(xv[g+1]), .o_d(xd[g+1])
        );
        d2p_div_cell u_ycell (
            .i_clk(i_clk), .i_rst_n(i_rst_n),
            .i_v(yv[g]), .i_d(yd[g]), .o_v(yv[g+1]), .o_d(yd[g+1])
        );
    end

    // saturate and apply signs
    logic [47:0] qx, qy;
    logic [31:0] zq_fin;
    logic [31:0] sx, sy;
    logic        r_valid;
    t_point      r_point;

    always_comb begin
        qx     = xd[LAT_N].quo;
        qy     = yd[LAT_N].quo;
        zq_fin = xd[LAT_N].side.aux;
        if (qx >= 48'h0000_8000_0000) begin
            sx = xd[LAT_N].side.neg_x ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
            sx = xd[LAT_N].side.neg_x ? (32'd0 - qx[31:0]) : qx[31:0];
        end
        if (qy >= 48'h0000_8000_0000) begin
            sy = xd[LAT_N].side.neg_y ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
            sy = xd[LAT_N].side.neg_y ? (32'd0 - qy[31:0]) : qy[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= xv[LAT_N];
        end
    end

    always_ff @(posedge i_clk) begin
        r_point.point_x   <= sx;
        r_point.point_y   <= sy;
        r_point.point_z   <= zq_fin[31] ? 31'h7FFF_FFFF : zq_fin[30:0];
        r_point.blue_out  <= xd[LAT_N].side.blue;
        r_point.green_out <= xd[LAT_N].side.green;
        r_point.red_out   <= xd[LAT_N].side.red;
    end

    assign o_valid = r_valid;
    assign o_point = r_point;

`ifndef SYNTHESIS
    // only positive disparities enter the depth divider
    a_disp_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_v |-> (!r_a_disp[15] && r_a_disp != 16'sd0))
        else $error("non-positive disparity in divider");
    // a zero depth never reaches the z divider
    a_depth_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_v |-> (r_b_depth != 16'd0))
        else $error("zero depth passed the check");
    // x and y chains stay in lockstep
    a_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        xv == yv)
        else $error("lateral chains out of step");
`endif

endmodule
